// File: hdl/static_linked_list_manager_assert.svh
// Assertion macros for the linked list manager RTL.
`ifndef STATIC_LINKED_LIST_MANAGER_ASSERT_SVH
`define STATIC_LINKED_LIST_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLLM_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("linked list manager check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLLM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("linked list manager check failed");

`endif

// File: hdl/sllm_pkg.sv
// Shared constants, types and helpers of the linked list manager.
`default_nettype none

package sllm_pkg;

    localparam int POOL_SIZE   = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int SLOT_W      = $clog2(POOL_SIZE);
    localparam int LINK_W      = $clog2(POOL_SIZE + 1);
    localparam int COUNT_W     = LINK_W;

    localparam int KIND_W     = 2;
    localparam int POS_W      = 6;
    localparam int SIZE_W     = 6;
    localparam int SLOT_OUT_W = 5;
    localparam int LIMIT_W    = 6;

    localparam logic [LINK_W-1:0]  NIL_LINK    = LINK_W'(POOL_SIZE);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 2'd0,
        KIND_ERASE     = 2'd1,
        KIND_PUSH_BACK = 2'd2,
        KIND_POP_BACK  = 2'd3
    } kind_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic [SLOT_W-1:0] rd_addr;
    } link_req_t;

    // Link held by a slot that was never written: the next slot, the last one wraps to 0.
    function automatic logic [LINK_W-1:0] link_reset_value(input logic [SLOT_W-1:0] idx);
        return (idx == SLOT_W'(POOL_SIZE - 1)) ? '0 : (LINK_W'(idx) + LINK_W'(1));
    endfunction

endpackage

`default_nettype wire

// File: hdl/sllm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/sllm_link_store.sv
// Link store: link RAM with per-slot valid bits for the reset pattern and write bypass.
`default_nettype none

module sllm_link_store (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sllm_pkg::link_req_t        req,
    output logic [sllm_pkg::LINK_W-1:0] rd_data
);

    import sllm_pkg::*;

    logic [POOL_SIZE-1:0] valid_reg;
    logic [POOL_SIZE-1:0] valid_next;
    logic [SLOT_W-1:0]    addr_q_reg;
    logic                 fwd_reg;
    logic [LINK_W-1:0]    fwd_data_reg;
    logic [LINK_W-1:0]    ram_rd_data;

    sllm_ram #(
        .WIDTH(LINK_W),
        .DEPTH(POOL_SIZE)
    ) u_link_ram (
        .clk    (clk),
        .we     (req.we),
        .wr_addr(req.wr_addr),
        .wr_data(req.wr_data),
        .rd_addr(req.rd_addr),
        .rd_data(ram_rd_data)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            fwd_reg   <= req.we && (req.wr_addr == req.rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        addr_q_reg   <= req.rd_addr;
        fwd_data_reg <= req.wr_data;
    end

    // A slot that was never written still holds its reset link.
    assign rd_data = fwd_reg               ? fwd_data_reg :
                     valid_reg[addr_q_reg] ? ram_rd_data  :
                                             link_reset_value(addr_q_reg);

endmodule

`default_nettype wire

// File: hdl/static_linked_list_manager.sv
// Top level of the linked list manager: request sequencer, pool state and result register.
`default_nettype none
`include "static_linked_list_manager_assert.svh"

// One singly linked list of up to 32 nodes with a free chain in the same link memory. A
// positional request walks position-1 links, push back size-1 and pop back size-2. The
// walk is paced by the link memory's single read port, which follows one link per cycle.
// The next word is taken as soon as the result is in the output register, and that
// register holds while out_ready is low. No clearing pass after reset.
module static_linked_list_manager (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [sllm_pkg::LIMIT_W-1:0]         cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sllm_pkg::KIND_W-1:0]          kind,
    input  logic signed [sllm_pkg::VALUE_WIDTH-1:0] value,
    input  logic [sllm_pkg::POS_W-1:0]           position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 ok,
    output logic [sllm_pkg::SIZE_W-1:0]          list_size,
    output logic [sllm_pkg::SLOT_OUT_W-1:0]      slot
);

    import sllm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_WALK    = 7'b0000010,
        S_READ_A  = 7'b0000100,
        S_READ_B  = 7'b0001000,
        S_WRITE_A = 7'b0010000,
        S_WRITE_B = 7'b0100000,
        S_RESP    = 7'b1000000
    } state_t;

    state_t                  state_reg, state_next;
    kind_t                   kind_reg, kind_next;
    logic [VALUE_WIDTH-1:0]  value_reg, value_next;
    logic [COUNT_W-1:0]      steps_reg, steps_next;
    logic [SLOT_W-1:0]       prev_reg, prev_next;
    logic [SLOT_W-1:0]       s_reg, s_next;
    logic [LINK_W-1:0]       next_reg, next_next;
    logic                    at_head_reg, at_head_next;
    logic                    ok_reg, ok_next;
    logic [LINK_W-1:0]       head_reg, head_next;
    logic [SLOT_W-1:0]       free_head_reg, free_head_next;
    logic [COUNT_W-1:0]      node_count_reg, node_count_next;
    logic [COUNT_W-1:0]      used_count_reg, used_count_next;
    logic [LIMIT_W-1:0]      limit_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    ok_out_reg, ok_out_next;
    logic [SIZE_W-1:0]       list_size_reg, list_size_next;
    logic [SLOT_OUT_W-1:0]   slot_reg, slot_next;

    link_req_t               link_req;
    logic [LINK_W-1:0]       link_rd;
    logic                    val_we;

    kind_t                   kind_in;
    logic [COUNT_W-1:0]      pos_in;
    logic                    accept;
    logic                    accept_ok;
    logic                    head_case;
    logic [COUNT_W-1:0]      walk_n;
    logic                    pool_free;

    sllm_link_store u_links (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (link_req),
        .rd_data(link_rd)
    );

    // Node values are kept for the pool but never appear in a result.
    sllm_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(POOL_SIZE)
    ) u_value_ram (
        .clk    (clk),
        .we     (val_we),
        .wr_addr(s_reg),
        .wr_data(value_reg),
        .rd_addr(s_reg),
        .rd_data()
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign kind_in  = kind_t'(kind);
    assign pos_in   = COUNT_W'(position);
    assign pool_free = (used_count_reg < COUNT_W'(POOL_SIZE));

    // Admission check and walk length of the word at the input.
    always_comb
    begin
        accept_ok = 1'b0;
        head_case = 1'b0;
        walk_n    = '0;
        case (kind_in)
            KIND_INSERT:
            begin
                accept_ok = pool_free && (pos_in <= node_count_reg);
                head_case = (pos_in == '0);
                walk_n    = pos_in - COUNT_W'(1);
            end
            KIND_ERASE:
            begin
                accept_ok = (pos_in < node_count_reg);
                head_case = (pos_in == '0);
                walk_n    = pos_in - COUNT_W'(1);
            end
            KIND_PUSH_BACK:
            begin
                accept_ok = pool_free && (COUNT_W'(node_count_reg) < COUNT_W'(limit_reg));
                head_case = (node_count_reg == '0);
                walk_n    = node_count_reg - COUNT_W'(1);
            end
            KIND_POP_BACK:
            begin
                accept_ok = (node_count_reg != '0);
                head_case = (node_count_reg == COUNT_W'(1));
                walk_n    = node_count_reg - COUNT_W'(2);
            end
            default:
            begin
                accept_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        steps_next      = steps_reg;
        prev_next       = prev_reg;
        s_next          = s_reg;
        next_next       = next_reg;
        at_head_next    = at_head_reg;
        ok_next         = ok_reg;
        head_next       = head_reg;
        free_head_next  = free_head_reg;
        node_count_next = node_count_reg;
        used_count_next = used_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ok_out_next     = ok_out_reg;
        list_size_next  = list_size_reg;
        slot_next       = slot_reg;
        link_req        = '0;
        val_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = kind_in;
                    value_next = value;
                    ok_next    = accept_ok;
                    if (!accept_ok)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        at_head_next = head_case;
                        s_next = (kind_in inside {KIND_INSERT, KIND_PUSH_BACK}) ?
                                 free_head_reg : head_reg[SLOT_W-1:0];
                        if (head_case)
                        begin
                            state_next = (kind_in == KIND_POP_BACK) ? S_WRITE_B : S_READ_B;
                        end
                        else if (walk_n == '0)
                        begin
                            prev_next  = head_reg[SLOT_W-1:0];
                            state_next = (kind_in == KIND_PUSH_BACK) ? S_READ_B : S_READ_A;
                        end
                        else
                        begin
                            link_req.rd_addr = head_reg[SLOT_W-1:0];
                            steps_next       = walk_n;
                            state_next       = S_WALK;
                        end
                    end
                end
            end

            // One link followed per cycle; the last one read is the predecessor.
            S_WALK:
            begin
                if (steps_reg == COUNT_W'(1))
                begin
                    prev_next  = link_rd[SLOT_W-1:0];
                    state_next = (kind_reg == KIND_PUSH_BACK) ? S_READ_B : S_READ_A;
                end
                else
                begin
                    link_req.rd_addr = link_rd[SLOT_W-1:0];
                    steps_next       = steps_reg - COUNT_W'(1);
                end
            end

            S_READ_A:
            begin
                link_req.rd_addr = prev_reg;
                state_next       = S_READ_B;
            end

            S_READ_B:
            begin
                link_req.rd_addr = s_reg;
                if (!at_head_reg && (kind_reg == KIND_INSERT))
                begin
                    next_next = link_rd;
                end
                if (!at_head_reg && (kind_reg inside {KIND_ERASE, KIND_POP_BACK}))
                begin
                    s_next           = link_rd[SLOT_W-1:0];
                    link_req.rd_addr = link_rd[SLOT_W-1:0];
                end
                state_next = S_WRITE_A;
            end

            S_WRITE_A:
            begin
                case (kind_reg)
                    KIND_INSERT, KIND_PUSH_BACK:
                    begin
                        free_head_next   = link_rd[SLOT_W-1:0];
                        val_we           = 1'b1;
                        link_req.we      = 1'b1;
                        link_req.wr_addr = s_reg;
                        if (kind_reg == KIND_PUSH_BACK)
                        begin
                            link_req.wr_data = NIL_LINK;
                        end
                        else
                        begin
                            link_req.wr_data = at_head_reg ? head_reg : next_reg;
                        end
                        if (at_head_reg)
                        begin
                            head_next = LINK_W'(s_reg);
                        end
                    end
                    KIND_ERASE:
                    begin
                        if (at_head_reg)
                        begin
                            head_next = link_rd;
                        end
                        else
                        begin
                            link_req.we      = 1'b1;
                            link_req.wr_addr = prev_reg;
                            link_req.wr_data = link_rd;
                        end
                    end
                    KIND_POP_BACK:
                    begin
                        link_req.we      = 1'b1;
                        link_req.wr_addr = prev_reg;
                        link_req.wr_data = NIL_LINK;
                    end
                    default:
                    begin
                        link_req.we = 1'b0;
                    end
                endcase
                state_next = S_WRITE_B;
            end

            S_WRITE_B:
            begin
                if (kind_reg inside {KIND_INSERT, KIND_PUSH_BACK})
                begin
                    if (!at_head_reg)
                    begin
                        link_req.we      = 1'b1;
                        link_req.wr_addr = prev_reg;
                        link_req.wr_data = LINK_W'(s_reg);
                    end
                    node_count_next = node_count_reg + COUNT_W'(1);
                    used_count_next = used_count_reg + COUNT_W'(1);
                end
                else
                begin
                    // The freed slot goes back on top of the free chain.
                    link_req.we      = 1'b1;
                    link_req.wr_addr = s_reg;
                    link_req.wr_data = LINK_W'(free_head_reg);
                    free_head_next   = s_reg;
                    node_count_next  = node_count_reg - COUNT_W'(1);
                    used_count_next  = used_count_reg - COUNT_W'(1);
                    if (node_count_reg == COUNT_W'(1))
                    begin
                        head_next = NIL_LINK;
                    end
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ok_out_next    = ok_reg;
                    list_size_next = SIZE_W'(node_count_reg);
                    slot_next      = ok_reg ? SLOT_OUT_W'(s_reg) : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= NIL_LINK;
            free_head_reg  <= '0;
            node_count_reg <= '0;
            used_count_reg <= '0;
            limit_reg      <= LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            free_head_reg  <= free_head_next;
            node_count_reg <= node_count_next;
            used_count_reg <= used_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        value_reg     <= value_next;
        steps_reg     <= steps_next;
        prev_reg      <= prev_next;
        s_reg         <= s_next;
        next_reg      <= next_next;
        at_head_reg   <= at_head_next;
        ok_reg        <= ok_next;
        ok_out_reg    <= ok_out_next;
        list_size_reg <= list_size_next;
        slot_reg      <= slot_next;
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_out_reg;
    assign list_size = list_size_reg;
    assign slot      = slot_reg;

    `SLLM_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
    `SLLM_ASSERT_SAME(a_counts_agree, 1'b1, used_count_reg == node_count_reg)
    `SLLM_ASSERT_SAME(a_empty_head_null, state_reg == S_IDLE,
        (head_reg == NIL_LINK) == (node_count_reg == '0))
    `SLLM_ASSERT_NEXT(a_refused_keeps_state, accept && !accept_ok,
        $stable(node_count_reg) && $stable(free_head_reg) && $stable(head_reg))

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the linked list manager: directed and random words, stalls and checks.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sllm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        logic                  ok;
        logic [SIZE_W-1:0]     size;
        logic [SLOT_OUT_W-1:0] slot;
    } outcome_t;

    // Tracks the list and the free chain and keeps the outcomes still to come.
    class list_scoreboard;
        logic [LINK_W-1:0] links [POOL_SIZE];
        logic [LINK_W-1:0] free_top;
        logic [LINK_W-1:0] head;
        int unsigned       used;
        int unsigned       count;
        int unsigned       limit;
        outcome_t          due [$];
        int                errors;

        function new();
            for (int i = 0; i < POOL_SIZE; i++)
                links[i] = (i == POOL_SIZE - 1) ? '0 : LINK_W'(i + 1);
            free_top = '0;
            head     = NIL_LINK;
            used     = 0;
            count    = 0;
            limit    = LIMIT_RESET;
            errors   = 0;
        endfunction

        // A null or out-of-pool link reads as null and cannot be written.
        function logic [LINK_W-1:0] next_of(logic [LINK_W-1:0] idx);
            return (idx < POOL_SIZE) ? links[idx[SLOT_W-1:0]] : NIL_LINK;
        endfunction

        function void relink(logic [LINK_W-1:0] idx, logic [LINK_W-1:0] v);
            if (idx < POOL_SIZE)
                links[idx[SLOT_W-1:0]] = v;
        endfunction

        function logic [LINK_W-1:0] grab();
            logic [LINK_W-1:0] s;
            s = free_top;
            free_top = next_of(s);
            used++;
            return s;
        endfunction

        function void recycle(logic [LINK_W-1:0] s);
            relink(s, free_top);
            free_top = s;
            if (used > 0)
                used--;
        endfunction

        function logic [LINK_W-1:0] node_at(int unsigned steps);
            logic [LINK_W-1:0] j;
            j = head;
            for (int unsigned k = 0; k < steps; k++)
                j = next_of(j);
            return j;
        endfunction

        function void note_request(kind_t k, logic [POS_W-1:0] p);
            int unsigned       pos;
            logic              done;
            logic [LINK_W-1:0] s;
            logic [LINK_W-1:0] prev;
            outcome_t          r;
            pos  = p;
            done = 1'b0;
            s    = '0;
            case (k)
                KIND_INSERT:
                    if (used < POOL_SIZE && pos <= count)
                    begin
                        if (pos == 0)
                        begin
                            s = grab();
                            relink(s, head);
                            head = s;
                        end
                        else
                        begin
                            prev = node_at(pos - 1);
                            s = grab();
                            relink(s, next_of(prev));
                            relink(prev, s);
                        end
                        count++;
                        done = 1'b1;
                    end
                KIND_ERASE:
                    if (pos < count)
                    begin
                        if (pos == 0)
                        begin
                            s = head;
                            head = next_of(s);
                        end
                        else
                        begin
                            prev = node_at(pos - 1);
                            s = next_of(prev);
                            relink(prev, next_of(s));
                        end
                        recycle(s);
                        count--;
                        if (count == 0)
                            head = NIL_LINK;
                        done = 1'b1;
                    end
                KIND_PUSH_BACK:
                    if (count < limit && used < POOL_SIZE)
                    begin
                        if (count == 0)
                        begin
                            s = grab();
                            relink(s, NIL_LINK);
                            head = s;
                        end
                        else
                        begin
                            prev = node_at(count - 1);
                            s = grab();
                            relink(s, NIL_LINK);
                            relink(prev, s);
                        end
                        count++;
                        done = 1'b1;
                    end
                KIND_POP_BACK:
                    if (count > 0)
                    begin
                        if (count == 1)
                        begin
                            s = head;
                            recycle(s);
                            head = NIL_LINK;
                        end
                        else
                        begin
                            prev = node_at(count - 2);
                            s = next_of(prev);
                            recycle(s);
                            relink(prev, NIL_LINK);
                        end
                        count--;
                        done = 1'b1;
                    end
            endcase
            r.ok   = done;
            r.size = SIZE_W'(count);
            r.slot = done ? s[SLOT_OUT_W-1:0] : '0;
            due.push_back(r);
        endfunction

        function void check_result(logic ok_q, logic [SIZE_W-1:0] size_q,
                                   logic [SLOT_OUT_W-1:0] slot_q);
            outcome_t r;
            if (due.size() == 0)
            begin
                $display("%0t: result word with nothing expected: ok=%0b size=%0d slot=%0d",
                         $time, ok_q, size_q, slot_q);
                errors++;
                return;
            end
            r = due.pop_front();
            if (ok_q !== r.ok)
            begin
                $display("%0t: ok expected %0b actual %0b", $time, r.ok, ok_q);
                errors++;
            end
            if (size_q !== r.size)
            begin
                $display("%0t: list_size expected %0d actual %0d", $time, r.size, size_q);
                errors++;
            end
            if (slot_q !== r.slot)
            begin
                $display("%0t: slot expected %0d actual %0d", $time, r.slot, slot_q);
                errors++;
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]            cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [KIND_W-1:0]             kind = '0;
    logic signed [VALUE_WIDTH-1:0] value = '0;
    logic [POS_W-1:0]              position = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          ok;
    logic [SIZE_W-1:0]             list_size;
    logic [SLOT_OUT_W-1:0]         slot;

    list_scoreboard sb = new();

    int send_left = 0;
    bit send_calm = 1'b0;
    int recv_left = 0;
    bit recv_calm = 1'b0;
    bit hold_req  = 1'b0;
    int stall_cycles = 0;

    static_linked_list_manager uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .ok         (ok),
        .list_size  (list_size),
        .slot       (slot)
    );

    always #6 clk = ~clk;

    // Gaps come in stretches; some stretches run with no gaps at all.
    function automatic int draw_gap(inout int left, inout bit calm);
        if (left == 0)
        begin
            calm = ($urandom_range(0, 3) == 0);
            left = $urandom_range(10, 40);
        end
        left--;
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    task automatic offer_word(kind_t k, logic [VALUE_WIDTH-1:0] v, logic [POS_W-1:0] p);
        int gap;
        gap = draw_gap(send_left, send_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(k, p);
    endtask

    task automatic drain_all();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_limit(logic [LIMIT_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.limit = v;
    endtask

    task automatic directed_words();
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
        offer_word(KIND_ERASE, 32'h1234_5678, 6'd0);
        offer_word(KIND_INSERT, 32'h0000_0001, 6'd1);
        offer_word(KIND_INSERT, 32'h7FFF_FFFF, 6'd0);
        offer_word(KIND_PUSH_BACK, 32'h8000_0000, 6'd0);
        offer_word(KIND_INSERT, 32'hFFFF_FFFF, 6'd1);
        offer_word(KIND_INSERT, 32'h0000_0000, 6'd3);
        offer_word(KIND_INSERT, 32'h5555_5555, 6'd2);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd5);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd2);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd0);
        offer_word(KIND_PUSH_BACK, 32'hAAAA_AAAA, 6'd63);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd3);
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
        offer_word(KIND_INSERT, 32'hDEAD_BEEF, 6'd32);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd32);
        offer_word(KIND_PUSH_BACK, 32'h0F0F_0F0F, 6'd0);
        offer_word(KIND_ERASE, 32'h0000_0000, 6'd0);
        offer_word(KIND_PUSH_BACK, 32'hF0F0_F0F0, 6'd0);
        offer_word(KIND_INSERT, 32'h0000_0002, 6'd1);
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
        offer_word(KIND_POP_BACK, 32'h0000_0000, 6'd0);
    endtask

    // Mostly grows toward a random mark and shrinks back, with some noise words mixed in.
    task automatic random_words(int n_items, bit with_hold);
        bit          growing;
        int unsigned mark;
        int unsigned cnt;
        kind_t       k;
        logic [POS_W-1:0] p;
        growing = 1'b1;
        mark    = $urandom_range(1, POOL_SIZE);
        for (int i = 0; i < n_items; i++)
        begin
            if (with_hold && i == 20)
                hold_req = 1'b1;
            cnt = sb.count;
            if (growing && cnt >= mark && $urandom_range(0, 3) != 0)
            begin
                growing = 1'b0;
                mark = $urandom_range(0, cnt);
            end
            else if (!growing && cnt <= mark)
            begin
                growing = 1'b1;
                mark = $urandom_range(cnt, POOL_SIZE);
            end
            if ($urandom_range(0, 99) < 10)
            begin
                k = kind_t'($urandom_range(0, 3));
                p = POS_W'($urandom_range(0, 32));
            end
            else if (growing)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    k = KIND_PUSH_BACK;
                    p = POS_W'($urandom_range(0, 32));
                end
                else
                begin
                    k = KIND_INSERT;
                    if ($urandom_range(0, 15) == 0)
                        p = POS_W'((cnt + 1 > 32) ? 32 : cnt + 1);
                    else
                        p = POS_W'($urandom_range(0, cnt));
                end
            end
            else
            begin
                if ($urandom_range(0, 1) == 0 || cnt == 0)
                begin
                    k = KIND_POP_BACK;
                    p = POS_W'($urandom_range(0, 32));
                end
                else
                begin
                    k = KIND_ERASE;
                    if ($urandom_range(0, 15) == 0)
                        p = POS_W'(cnt);
                    else
                        p = POS_W'($urandom_range(0, cnt - 1));
                end
            end
            offer_word(k, $urandom, p);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_words();
        drain_all();

        set_limit(6'd32);
        random_words(115, 1'b0);
        drain_all();
        set_limit(6'd0);
        random_words(115, 1'b0);
        drain_all();
        set_limit(6'd1);
        random_words(115, 1'b0);
        drain_all();
        set_limit(6'd31);
        random_words(115, 1'b0);
        drain_all();
        set_limit(LIMIT_W'($urandom_range(2, 30)));
        random_words(115, 1'b0);
        drain_all();
        set_limit(6'd32);
        random_words(115, 1'b1);
        drain_all();
        set_limit(LIMIT_RESET);
        random_words(115, 1'b0);
        drain_all();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Result side: random ready gaps, one long hold on request from the sender.
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            gap = draw_gap(recv_left, recv_calm);
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = LONG_HOLD;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result(ok, list_size, slot);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, stall_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
